// ===== rtl/bcs_pkg.sv =====
`timescale 1ns / 1ps

package bcs_pkg;

  localparam int CAPTURE_DEPTH_DEF = 512;
  localparam int SLOT_W            = 9;
  localparam int ADDR_W            = 5;
  localparam int ROOT_STEPS        = 16;

  // breath phases
  localparam logic [2:0] PH_IDLE       = 3'd0;
  localparam logic [2:0] PH_WAIT_FIRST = 3'd1;
  localparam logic [2:0] PH_FIRST      = 3'd2;
  localparam logic [2:0] PH_WAIT_EX    = 3'd3;
  localparam logic [2:0] PH_EXHALE     = 3'd4;
  localparam logic [2:0] PH_WAIT_IN    = 3'd5;
  localparam logic [2:0] PH_INHALE     = 3'd6;

  // register map, index = paddr[4:2]
  localparam logic [2:0] REG_FIRST_THR = 3'd0;
  localparam logic [2:0] REG_IN_THR    = 3'd1;
  localparam logic [2:0] REG_EX_THR    = 3'd2;
  localparam logic [2:0] REG_MARGIN    = 3'd3;
  localparam logic [2:0] REG_TIMEOUT   = 3'd4;
  localparam logic [2:0] REG_RATIO     = 3'd5;

  localparam logic [14:0] RST_FIRST_THR = 15'd50;
  localparam logic [14:0] RST_IN_THR    = 15'd40;
  localparam logic [14:0] RST_EX_THR    = 15'd40;
  localparam logic [7:0]  RST_MARGIN    = 8'd5;
  localparam logic [15:0] RST_TIMEOUT   = 16'd500;
  localparam logic [15:0] RST_RATIO     = 16'd3277;

  typedef struct packed {
    logic [14:0] first_thr;
    logic [14:0] in_thr;
    logic [14:0] ex_thr;
    logic [7:0]  margin;
    logic [15:0] timeout;
    logic [15:0] ratio;
  } cfg_t;

  typedef struct packed {
    logic start;
    logic iter;
    logic commit;
    logic mul;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic root_last;
  } stat_t;

  typedef struct packed {
    logic [2:0]         phase;
    logic               recording;
    logic               is_inhale;
    logic [SLOT_W-1:0]  slot;
    logic               cycle_done;
    logic               timed_out;
    logic               failed;
    logic signed [31:0] exhale_volume;
    logic signed [31:0] residual_volume;
  } res_t;

endpackage

// ===== rtl/bcs_if.sv =====
`timescale 1ns / 1ps

interface bcs_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] pressure;
  logic               button;

  modport source (output valid, output pressure, output button, input ready);
  modport sink (input valid, input pressure, input button, output ready);
endinterface

interface bcs_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         phase;
  logic               recording;
  logic               is_inhale;
  logic [8:0]         slot;
  logic               cycle_done;
  logic               timed_out;
  logic               failed;
  logic signed [31:0] exhale_volume;
  logic signed [31:0] residual_volume;

  modport source (
    output valid, output phase, output recording, output is_inhale, output slot,
    output cycle_done, output timed_out, output failed, output exhale_volume,
    output residual_volume, input ready
  );
  modport sink (
    input valid, input phase, input recording, input is_inhale, input slot,
    input cycle_done, input timed_out, input failed, input exhale_volume,
    input residual_volume, output ready
  );
endinterface

// ===== rtl/breath_cycle_sequencer.sv =====
`timescale 1ns / 1ps
// Breath cycle sequencer for a spirometer front end.
// in_chan: one pressure sample (signed) and the start button per beat, valid/ready.
// out_chan: one result beat per sample: phase after the sample, capture slot,
//   cycle_done / timed_out / failed flags, exhale and residual volume (Q24.8).
// cfg_*: APB-style register port, registers at byte address 4*index, pready tied
//   high; write registers only while no sample is in flight.
// A sample is latched when accepted, then runs the 16-step square-root loop
//   in the datapath and the commit, multiply and load steps; the next sample
//   is accepted only after this result is loaded into the output register.
// in_ready is high only while no sample is in flight. A finished result waits
//   in the output register; when the receiver stalls, the next sample is still
//   processed but its result is held back until the previous beat is taken.
// Reset (rst_n low, synchronous): phase idle, volumes, tick and slot counters
//   cleared, registers back to their defaults, no result pending.
module breath_cycle_sequencer #(
  parameter int CAPTURE_DEPTH = bcs_pkg::CAPTURE_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  bcs_in_if.sink                     in_chan,
  bcs_out_if.source                  out_chan,
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [bcs_pkg::ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]                cfg_pwdata,
  output logic [31:0]                cfg_prdata,
  output logic                       cfg_pready
);
  import bcs_pkg::*;

  cfg_t  cfg;
  cmd_t  cmd;
  stat_t stat;
  res_t  res;

  bcs_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  bcs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_ready (out_chan.ready),
    .out_valid (out_chan.valid),
    .stat      (stat),
    .cmd       (cmd)
  );

  bcs_dp #(
    .CAPTURE_DEPTH (CAPTURE_DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .pressure (in_chan.pressure),
    .button   (in_chan.button),
    .cfg      (cfg),
    .cmd      (cmd),
    .stat     (stat),
    .res      (res)
  );

  assign out_chan.phase           = res.phase;
  assign out_chan.recording       = res.recording;
  assign out_chan.is_inhale       = res.is_inhale;
  assign out_chan.slot            = res.slot;
  assign out_chan.cycle_done      = res.cycle_done;
  assign out_chan.timed_out       = res.timed_out;
  assign out_chan.failed          = res.failed;
  assign out_chan.exhale_volume   = res.exhale_volume;
  assign out_chan.residual_volume = res.residual_volume;

endmodule

// ===== rtl/bcs_regs.sv =====
`timescale 1ns / 1ps

module bcs_regs (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [bcs_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output bcs_pkg::cfg_t              cfg
);
  import bcs_pkg::*;

  cfg_t       cfg_r;
  logic [2:0] idx;
  logic       wr_en;

  assign idx    = paddr[4:2];
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.first_thr <= RST_FIRST_THR;
      cfg_r.in_thr    <= RST_IN_THR;
      cfg_r.ex_thr    <= RST_EX_THR;
      cfg_r.margin    <= RST_MARGIN;
      cfg_r.timeout   <= RST_TIMEOUT;
      cfg_r.ratio     <= RST_RATIO;
    end else if (wr_en) begin
      unique case (idx)
        REG_FIRST_THR: cfg_r.first_thr <= pwdata[14:0];
        REG_IN_THR:    cfg_r.in_thr    <= pwdata[14:0];
        REG_EX_THR:    cfg_r.ex_thr    <= pwdata[14:0];
        REG_MARGIN:    cfg_r.margin    <= pwdata[7:0];
        REG_TIMEOUT:   cfg_r.timeout   <= pwdata[15:0];
        REG_RATIO:     cfg_r.ratio     <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_FIRST_THR: prdata = {17'd0, cfg_r.first_thr};
      REG_IN_THR:    prdata = {17'd0, cfg_r.in_thr};
      REG_EX_THR:    prdata = {17'd0, cfg_r.ex_thr};
      REG_MARGIN:    prdata = {24'd0, cfg_r.margin};
      REG_TIMEOUT:   prdata = {16'd0, cfg_r.timeout};
      REG_RATIO:     prdata = {16'd0, cfg_r.ratio};
      default:       prdata = 32'd0;
    endcase
  end

endmodule

// ===== rtl/bcs_ctrl.sv =====
`timescale 1ns / 1ps

module bcs_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic           out_ready,
  output logic           out_valid,
  input  bcs_pkg::stat_t stat,
  output bcs_pkg::cmd_t  cmd
);
  import bcs_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ROOT,
    S_COMMIT,
    S_MUL,
    S_LOAD
  } st_t;

  st_t  st_r;
  logic out_valid_r;
  logic out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (st_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd        = '0;
    cmd.start  = (st_r == S_IDLE) && in_valid;
    cmd.iter   = (st_r == S_ROOT);
    cmd.commit = (st_r == S_COMMIT);
    cmd.mul    = (st_r == S_MUL);
    cmd.load   = (st_r == S_LOAD) && out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      // a beat taken this cycle can be replaced by the next one at once
      if (st_r == S_LOAD && out_free) out_valid_r <= 1'b1;
      else if (out_ready)             out_valid_r <= 1'b0;
      unique case (st_r)
        S_IDLE:   if (in_valid) st_r <= S_ROOT;
        S_ROOT:   if (stat.root_last) st_r <= S_COMMIT;
        S_COMMIT: st_r <= S_MUL;
        S_MUL:    st_r <= S_LOAD;
        S_LOAD:   if (out_free) st_r <= S_IDLE;
        default:  st_r <= S_IDLE;
      endcase
    end
  end

  a_load_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> (!out_valid_r || out_ready))
    else $error("result loaded over an untaken beat");

  a_root_then_commit: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_ROOT && stat.root_last) |=> (st_r == S_COMMIT))
    else $error("root loop did not hand over to commit");

  a_start_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |=> (st_r == S_ROOT && !in_ready))
    else $error("input taken while a sample is in flight");

endmodule

// ===== rtl/bcs_dp.sv =====
`timescale 1ns / 1ps

module bcs_dp #(
  parameter int CAPTURE_DEPTH = bcs_pkg::CAPTURE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic signed [15:0] pressure,
  input  logic               button,
  input  bcs_pkg::cfg_t      cfg,
  input  bcs_pkg::cmd_t      cmd,
  output bcs_pkg::stat_t     stat,
  output bcs_pkg::res_t      res
);
  import bcs_pkg::*;

  localparam int CW = $clog2(CAPTURE_DEPTH);
  localparam int SW = $clog2(ROOT_STEPS);

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    logic signed [33:0] hi;
    logic signed [33:0] lo;
    hi = 34'sh0_7FFF_FFFF;
    lo = -34'sh0_8000_0000;
    if (v > hi) return 32'sh7FFF_FFFF;
    else if (v < lo) return -32'sh8000_0000;
    else return v[31:0];
  endfunction

  function automatic logic [31:0] abs32(input logic signed [31:0] v);
    return v[31] ? 32'(-v) : 32'(v);
  endfunction

  // sample latch and iterative square root
  logic signed [15:0] p_r;
  logic               btn_r;
  logic [31:0]        x_r, res_r, bit_r;
  logic [SW-1:0]      step_r;
  logic [15:0]        mag;
  logic [31:0]        trial;

  // architectural state
  logic [2:0]         phase_r;
  logic [16:0]        elapsed_r;
  logic [CW-1:0]      cnt_r;
  logic [15:0]        last_root_r;
  logic signed [31:0] run_r, peak_r;

  // held result of the commit step
  res_t               hold_r;
  logic [31:0]        abs_res_r, abs_ex_r;
  logic [47:0]        prod_r;
  res_t               out_r;
  res_t               load_v;

  // commit logic
  logic [2:0]         ph_nxt;
  logic [16:0]        el_nxt, el_inc;
  logic [CW-1:0]      cnt_nxt, cnt_inc;
  logic [15:0]        lr_nxt, root, inc;
  logic signed [31:0] run_nxt, pk_nxt;
  logic [16:0]        trap_sum;
  logic signed [33:0] run_ext, inc_ext;
  logic signed [16:0] p_ext, fall_in, fall_ex;
  logic               timed, rec, inh, done, tout;
  logic [CW-1:0]      slot_c;
  logic [SLOT_W+CW-1:0] slot_wide;
  logic signed [31:0] ev, rv;

  assign mag            = pressure[15] ? 16'(-pressure) : 16'(pressure);
  assign trial          = res_r + bit_r;
  assign stat.root_last = (step_r == SW'(ROOT_STEPS - 1));
  assign root           = res_r[15:0];

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      p_r    <= pressure;
      btn_r  <= button;
      step_r <= '0;
      bit_r  <= 32'h4000_0000;
      res_r  <= '0;
      x_r    <= {mag, 16'd0};
    end else if (cmd.iter) begin
      if (x_r >= trial) begin
        x_r   <= x_r - trial;
        res_r <= (res_r >> 1) + bit_r;
      end else begin
        res_r <= res_r >> 1;
      end
      bit_r  <= bit_r >> 2;
      step_r <= step_r + SW'(1);
    end
  end

  assign el_inc   = (elapsed_r == '1) ? elapsed_r : elapsed_r + 17'd1;
  assign timed    = el_inc > {1'b0, cfg.timeout};
  assign trap_sum = {1'b0, last_root_r} + {1'b0, root};
  assign inc      = trap_sum[16:1];
  assign run_ext  = 34'(run_r);
  assign inc_ext  = $signed({18'd0, inc});
  assign cnt_inc  = (cnt_r < CW'(CAPTURE_DEPTH - 1)) ? cnt_r + CW'(1) : cnt_r;
  assign p_ext    = 17'(p_r);
  assign fall_in  = $signed({2'b00, cfg.in_thr}) - $signed({9'd0, cfg.margin});
  assign fall_ex  = $signed({2'b00, cfg.ex_thr}) - $signed({9'd0, cfg.margin});

  always_comb begin
    ph_nxt  = phase_r;
    el_nxt  = elapsed_r;
    cnt_nxt = cnt_r;
    lr_nxt  = last_root_r;
    run_nxt = run_r;
    pk_nxt  = peak_r;
    rec     = 1'b0;
    inh     = 1'b0;
    slot_c  = '0;
    done    = 1'b0;
    tout    = 1'b0;
    ev      = '0;
    rv      = '0;
    if (phase_r == PH_IDLE || phase_r > PH_INHALE) begin
      ph_nxt = PH_IDLE;
      if (btn_r) begin
        ph_nxt  = PH_WAIT_FIRST;
        el_nxt  = '0;
        lr_nxt  = '0;
        run_nxt = '0;
        pk_nxt  = '0;
      end
    end else begin
      el_nxt = el_inc;
      unique case (phase_r)
        PH_WAIT_FIRST: if (p_ext > $signed({2'b00, cfg.first_thr})) ph_nxt = PH_FIRST;
        PH_FIRST:      if (p_ext < fall_in) ph_nxt = PH_WAIT_EX;
        PH_WAIT_EX: begin
          if (p_ext > $signed({2'b00, cfg.ex_thr})) begin
            ph_nxt  = PH_EXHALE;
            cnt_nxt = '0;
            lr_nxt  = '0;
          end
        end
        PH_EXHALE: begin
          rec     = 1'b1;
          slot_c  = cnt_r;
          cnt_nxt = cnt_inc;
          lr_nxt  = root;
          run_nxt = sat32(run_ext + inc_ext);
          if (p_ext < fall_ex) begin
            ph_nxt = PH_WAIT_IN;
            if (!timed) pk_nxt = run_nxt;
          end
        end
        PH_WAIT_IN: begin
          if (p_ext > $signed({2'b00, cfg.in_thr})) begin
            ph_nxt  = PH_INHALE;
            cnt_nxt = '0;
            lr_nxt  = '0;
          end
        end
        default: begin
          rec     = 1'b1;
          inh     = 1'b1;
          slot_c  = cnt_r;
          cnt_nxt = cnt_inc;
          lr_nxt  = root;
          run_nxt = sat32(run_ext - inc_ext);
          if (p_ext < fall_in) ph_nxt = PH_IDLE;
        end
      endcase
      // timeout overrides any phase change on the same sample
      if (timed) begin
        tout   = 1'b1;
        ph_nxt = PH_IDLE;
      end else if (ph_nxt != phase_r) begin
        el_nxt = '0;
        if (phase_r == PH_INHALE) begin
          done = 1'b1;
          ev   = peak_r;
          rv   = run_nxt;
        end
      end
    end
  end

  assign slot_wide = {{SLOT_W{1'b0}}, slot_c};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      elapsed_r   <= '0;
      cnt_r       <= '0;
      last_root_r <= '0;
      run_r       <= '0;
      peak_r      <= '0;
    end else if (cmd.commit) begin
      phase_r     <= ph_nxt;
      elapsed_r   <= el_nxt;
      cnt_r       <= cnt_nxt;
      last_root_r <= lr_nxt;
      run_r       <= run_nxt;
      peak_r      <= pk_nxt;
    end
  end

  always_comb begin
    load_v        = hold_r;
    load_v.failed = hold_r.cycle_done && ({abs_res_r, 16'd0} > prod_r);
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      hold_r.phase           <= ph_nxt;
      hold_r.recording       <= rec;
      hold_r.is_inhale       <= inh;
      hold_r.slot            <= slot_wide[SLOT_W-1:0];
      hold_r.cycle_done      <= done;
      hold_r.timed_out       <= tout;
      hold_r.failed          <= 1'b0;
      hold_r.exhale_volume   <= ev;
      hold_r.residual_volume <= rv;
      abs_res_r              <= abs32(rv);
      abs_ex_r               <= abs32(ev);
    end
    if (cmd.mul) prod_r <= {32'd0, cfg.ratio} * {16'd0, abs_ex_r};
    if (cmd.load) out_r <= load_v;
  end

  assign res = out_r;

  a_phase_legal: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r <= PH_INHALE)
    else $error("phase register holds the unused code");

  a_timeout_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.commit && tout) |=> (phase_r == PH_IDLE && !hold_r.cycle_done))
    else $error("timeout did not return to idle");

endmodule
